>>> rtl/core/u8ss_pkg.sv
package u8ss_pkg;

    // Sizes of the needle, the text offsets and the result queue.
    localparam int NEEDLE_MAX_BYTES = 16;
    localparam int NIDX_W           = 4;
    localparam int NEEDLE_W         = 8 * NEEDLE_MAX_BYTES;
    localparam int LEN_W            = 5;
    localparam int CNT_W            = 5;
    localparam int OFF_W            = 21;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int QDEPTH           = 4;
    localparam int QPTR_W           = 2;
    localparam int QCNT_W           = 3;
    localparam int TDATA_OUT_W      = 72;

    localparam logic [OFF_W-1:0] TEXT_MAX_CODEPOINTS = 21'd1048576;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND       = 3'd4;

    // Search modes.
    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;

    // Summary status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // Result kinds.
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Sequence length codes of a UTF-8 lead byte.
    localparam logic [2:0] SEQ_BAD   = 3'd0;
    localparam logic [2:0] SEQ_ONE   = 3'd1;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // Needle settings as seen by the scanner.
    typedef struct packed {
        logic [1:0]          mode;
        logic [NEEDLE_W-1:0] bytes;
        logic [LEN_W-1:0]    length;
        logic [OFF_W-1:0]    bound;
        logic [CNT_W-1:0]    ncp;
        logic                busy;
    } t_needle_cfg;

    // One result item.
    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] mstart;
        logic [OFF_W-1:0] mend;
        logic [OFF_W-1:0] mcount;
        logic [1:0]       status;
        logic             last;
    } t_result;

    // Up to two result items produced by one accepted byte.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Sequence length announced by a lead byte, SEQ_BAD if it cannot lead.
    function automatic logic [2:0] utf8_seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = SEQ_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = SEQ_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = SEQ_THREE;
        end else if (b[7:3] == 5'b11110) begin
            len = SEQ_FOUR;
        end else begin
            len = SEQ_BAD;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic [7:0] needle_byte(input logic [NEEDLE_W-1:0] n,
                                               input logic [NIDX_W-1:0]   i);
        return n[{i, 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/core/u8ss_needle.sv
module u8ss_needle import u8ss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_needle_cfg           o_cfg
);

    logic [1:0]          r_mode;
    logic [NEEDLE_W-1:0] r_bytes;
    logic [LEN_W-1:0]    r_len;
    logic [OFF_W-1:0]    r_bound;
    logic [CNT_W-1:0]    r_ncp;
    logic                r_busy;
    logic [LEN_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_cnt;

    logic                cfg_hit;
    logic [7:0]          b0, b1, b2, b3;
    logic [2:0]          need;
    logic [LEN_W-1:0]    n_pos;
    logic                len_bad;
    logic                step_fail;

    assign o_cfg_ready = 1'b1;

    // Only the five defined indexes touch the registers.
    assign cfg_hit = i_cfg_valid && (i_cfg_index <= CFG_BOUND);

    // One codepoint of the needle is checked per cycle.
    always_comb begin
        b0        = needle_byte(r_bytes, r_pos[NIDX_W-1:0]);
        b1        = needle_byte(r_bytes, r_pos[NIDX_W-1:0] + 4'd1);
        b2        = needle_byte(r_bytes, r_pos[NIDX_W-1:0] + 4'd2);
        b3        = needle_byte(r_bytes, r_pos[NIDX_W-1:0] + 4'd3);
        need      = utf8_seq_len(b0);
        n_pos     = r_pos + LEN_W'(need);
        len_bad   = (r_len == '0) || (r_len > LEN_W'(NEEDLE_MAX_BYTES));
        step_fail = (need == SEQ_BAD) || (n_pos > r_len)
                 || ((need >= SEQ_TWO) && !is_cont(b1))
                 || ((need >= SEQ_THREE) && !is_cont(b2))
                 || ((need == SEQ_FOUR) && !is_cont(b3));
    end

    // Register writes restart the codepoint count of the needle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ALL;
            r_bytes <= '0;
            r_len   <= LEN_W'(1);
            r_bound <= '0;
            r_ncp   <= CNT_W'(1);
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode <= i_cfg_data[1:0];
                CFG_NEEDLE_LOW:  r_bytes[CFG_DATA_W-1:0] <= i_cfg_data;
                CFG_NEEDLE_HIGH: r_bytes[NEEDLE_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_NEEDLE_LEN:  r_len <= i_cfg_data[LEN_W-1:0];
                CFG_BOUND:       r_bound <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
            r_busy <= 1'b1;
            r_pos  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            priority if (len_bad) begin
                r_ncp  <= '0;
                r_busy <= 1'b0;
            end else if (r_pos >= r_len) begin
                r_ncp  <= r_cnt;
                r_busy <= 1'b0;
            end else if (step_fail) begin
                r_ncp  <= '0;
                r_busy <= 1'b0;
            end else begin
                r_pos <= n_pos;
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_cfg.mode   = r_mode;
    assign o_cfg.bytes  = r_bytes;
    assign o_cfg.length = r_len;
    assign o_cfg.bound  = r_bound;
    assign o_cfg.ncp    = r_ncp;
    assign o_cfg.busy   = r_busy;

endmodule

>>> rtl/core/u8ss_front.sv
module u8ss_front import u8ss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_final,
    input  t_needle_cfg i_cfg,
    output t_push       o_push
);

    logic [7:0]       r_win [NEEDLE_MAX_BYTES];
    logic [NEEDLE_MAX_BYTES-1:0] r_bnd;
    logic [OFF_W-1:0] r_off;
    logic [1:0]       r_cl;
    logic [OFF_W-1:0] r_prev;
    logic [OFF_W-1:0] r_found;
    logic [OFF_W-1:0] r_bs;
    logic             r_bf;
    logic             r_mal;

    logic [7:0]       n_win [NEEDLE_MAX_BYTES];
    logic [NEEDLE_MAX_BYTES-1:0] n_bnd;
    logic [OFF_W-1:0] n_off;
    logic [1:0]       n_cl;
    logic [OFF_W-1:0] n_prev;
    logic [OFF_W-1:0] n_found;
    logic [OFF_W-1:0] n_bs;
    logic             n_bf;
    logic             n_mal;

    logic             lead;
    logic             complete;
    logic [2:0]       sl;
    logic [NIDX_W-1:0] lidx;
    logic             len_ok;
    logic [NEEDLE_MAX_BYTES-1:0] eq;
    logic             hit;
    logic [OFF_W-1:0] ncp_ext;
    logic [OFF_W-1:0] m_start;
    logic             rep;
    t_result          rep_r;
    t_result          sum_r;
    logic [OFF_W-1:0] eff;
    logic             bad;

    // Decode the byte against the open sequence and shift the window.
    always_comb begin
        sl       = utf8_seq_len(i_byte);
        n_cl     = r_cl;
        n_off    = r_off;
        n_mal    = r_mal;
        lead     = 1'b0;
        complete = 1'b0;
        if (r_cl != 2'd0) begin
            if (is_cont(i_byte)) begin
                n_cl     = r_cl - 2'd1;
                complete = (r_cl == 2'd1);
            end else begin
                n_mal = 1'b1;
                n_cl  = 2'd0;
                lead  = 1'b1;
            end
        end else begin
            lead = 1'b1;
        end
        if (lead) begin
            if (r_off >= TEXT_MAX_CODEPOINTS) begin
                n_mal = 1'b1;
            end else begin
                n_off = r_off + OFF_W'(1);
            end
            unique case (sl)
                SEQ_ONE:   complete = 1'b1;
                SEQ_TWO:   n_cl = 2'd1;
                SEQ_THREE: n_cl = 2'd2;
                SEQ_FOUR:  n_cl = 2'd3;
                default: begin
                    n_mal    = 1'b1;
                    complete = 1'b1;
                end
            endcase
        end
        n_win[0] = i_byte;
        for (int i = 1; i < NEEDLE_MAX_BYTES; i++) begin
            n_win[i] = r_win[i-1];
        end
        n_bnd = {r_bnd[NEEDLE_MAX_BYTES-2:0], lead};
        if (i_final && (n_cl != 2'd0)) begin
            n_mal = 1'b1;
        end
    end

    // Parallel compare of the newest needle-length bytes.
    always_comb begin
        lidx    = NIDX_W'(i_cfg.length - LEN_W'(1));
        len_ok  = (i_cfg.length != '0) && (i_cfg.length <= LEN_W'(NEEDLE_MAX_BYTES));
        ncp_ext = OFF_W'(i_cfg.ncp);
        for (int k = 0; k < NEEDLE_MAX_BYTES; k++) begin
            eq[k] = (LEN_W'(k) >= i_cfg.length)
                 || (n_win[lidx - NIDX_W'(k)] == needle_byte(i_cfg.bytes, NIDX_W'(k)));
        end
        hit = complete && !n_mal && (i_cfg.ncp != '0) && (n_off >= ncp_ext)
           && len_ok && n_bnd[lidx] && (&eq);
    end

    // Apply the mode to a match and build the summary.
    always_comb begin
        m_start = n_off - ncp_ext;
        n_prev  = r_prev;
        n_found = r_found;
        n_bs    = r_bs;
        n_bf    = r_bf;
        rep     = 1'b0;

        rep_r.kind   = KIND_MATCH;
        rep_r.mstart = m_start;
        rep_r.mend   = n_off;
        rep_r.mcount = '0;
        rep_r.status = ST_OK;
        rep_r.last   = !i_final;

        unique case (i_cfg.mode)
            MODE_ALL: begin
                if (hit && (m_start >= i_cfg.bound) && (m_start >= r_prev)) begin
                    n_prev       = n_off;
                    n_found      = r_found + OFF_W'(1);
                    rep          = 1'b1;
                    rep_r.mcount = n_found;
                end
            end
            MODE_FIRST: begin
                if (hit && !r_bf && (m_start >= i_cfg.bound)) begin
                    n_bf = 1'b1;
                    n_bs = m_start;
                    rep  = 1'b1;
                end
            end
            MODE_LAST: begin
                if (hit && (n_off <= i_cfg.bound)) begin
                    n_bf = 1'b1;
                    n_bs = m_start;
                end
            end
            default: begin
            end
        endcase

        eff = (i_cfg.bound > n_off) ? n_off : i_cfg.bound;
        if (i_cfg.mode == MODE_FIRST) begin
            bad = (n_off < ncp_ext) || (i_cfg.bound > n_off - ncp_ext);
        end else begin
            bad = (i_cfg.bound == '0) || (n_off < ncp_ext) || (eff < ncp_ext);
        end

        sum_r.kind   = KIND_SUMMARY;
        sum_r.mstart = '0;
        sum_r.mend   = '0;
        sum_r.mcount = '0;
        sum_r.status = ST_INVALID;
        sum_r.last   = 1'b1;
        priority if (i_cfg.ncp == '0) begin
            sum_r.status = ST_INVALID;
        end else if (n_mal) begin
            sum_r.status = ST_MALFORMED;
        end else if (i_cfg.mode == MODE_ALL) begin
            sum_r.mcount = n_found;
            sum_r.status = ST_OK;
        end else if ((i_cfg.mode == MODE_FIRST) || (i_cfg.mode == MODE_LAST)) begin
            if (n_bf) begin
                sum_r.mstart = n_bs;
                sum_r.mend   = n_bs + ncp_ext;
                sum_r.status = ST_OK;
            end else begin
                sum_r.status = bad ? ST_INVALID : ST_NOT_FOUND;
            end
        end else begin
            sum_r.status = ST_INVALID;
        end

        o_push.n  = i_fire ? ({1'b0, rep} + {1'b0, i_final}) : 2'd0;
        o_push.r0 = rep ? rep_r : sum_r;
        o_push.r1 = sum_r;
    end

    // The window bytes are only trusted where a boundary flag covers them.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int i = 0; i < NEEDLE_MAX_BYTES; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // Per-text state, cleared after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd   <= '0;
            r_off   <= '0;
            r_cl    <= 2'd0;
            r_prev  <= '0;
            r_found <= '0;
            r_bs    <= '0;
            r_bf    <= 1'b0;
            r_mal   <= 1'b0;
        end else if (i_fire) begin
            if (i_final) begin
                r_bnd   <= '0;
                r_off   <= '0;
                r_cl    <= 2'd0;
                r_prev  <= '0;
                r_found <= '0;
                r_bs    <= '0;
                r_bf    <= 1'b0;
                r_mal   <= 1'b0;
            end else begin
                r_bnd   <= n_bnd;
                r_off   <= n_off;
                r_cl    <= n_cl;
                r_prev  <= n_prev;
                r_found <= n_found;
                r_bs    <= n_bs;
                r_bf    <= n_bf;
                r_mal   <= n_mal;
            end
        end
    end

endmodule

>>> rtl/core/u8ss_outq.sv
module u8ss_outq import u8ss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_room
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    // Room for the two items a final byte can bring.
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push.n);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.n) - QCNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> ((QCNT_W + 1)'(r_count) + (QCNT_W + 1)'(i_push.n)
                                <= (QCNT_W + 1)'(QDEPTH)))
        else $error("result push overflows the queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push.n == 2'd0)) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("result queue count did not drop after a pop");
`endif

endmodule

>>> rtl/core/utf8_substring_search_unit.sv
// Channel  | Direction | Handshake               | Payload
// s_axis   | in        | tvalid / tready         | tdata: text_byte, tlast: final_byte
// m_axis   | out       | tvalid / tready         | tdata: match fields, tuser: result_kind,
//          |           |                         | tlast: last_result
// cfg      | in        | valid / ready           | index, data (register write)
//
// One text byte is taken per cycle; match compare and UTF-8 decode finish in that cycle.
// Results pass through a four-item queue drained one item per cycle while m_axis_tready is
// high, so a final byte with a match (two items) fills two queue slots at once.
// Input stalls while the queue holds more than two items, and after a register write
// while the needle is walked one codepoint per cycle.
// Reset is synchronous, active low; it restores register defaults and clears the per-text
// state apart from the byte window, whose boundary flags it does clear.
module utf8_substring_search_unit import u8ss_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] text_byte
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // [20:0] match_start, [41:21] match_end,
                                                     // [62:42] match_total, [64:63] status
    output logic                   o_m_axis_tuser,   // [0] result_kind
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_needle_cfg cfg;
    t_push       push;
    t_result     head;
    logic        room;
    logic        fire;

    // Needle registers and codepoint count.
    u8ss_needle u_needle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input handshake.
    assign o_s_axis_tready = room && !cfg.busy;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    // Decode and match front end.
    u8ss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_s_axis_tdata),
        .i_final (i_s_axis_tlast),
        .i_cfg   (cfg),
        .o_push  (push)
    );

    // Result queue toward the output channel.
    u8ss_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head),
        .o_room  (room)
    );

    assign o_m_axis_tdata = {7'b0, head.status, head.mcount, head.mend, head.mstart};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import u8ss_pkg::*;

    // Mode code that the block must treat as unknown.
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;
    // Cycles the sender stays quiet after the last awaited result before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver hold-off.
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int RANDOM_BYTES = 1250;

    typedef enum logic [1:0] {
        FEED_BYTE,
        FEED_REG,
        FEED_SYNC
    } t_feed_kind;

    // One pending action for the driver: a text byte, a register write or a sync point.
    typedef struct packed {
        t_feed_kind           what;
        logic [7:0]           data;
        logic                 final_byte;
        logic                 hold;
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          value;
    } t_feed_entry;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [7:0]             i_s_axis_tdata = 8'h00;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;
    logic                   o_cfg_ready;

    utf8_substring_search_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_feed_entry text_feed[$];
    t_result     awaited_results[$];
    logic [7:0]  text_buf[$];
    logic [7:0]  needle_buf[$];
    int          bytes_queued = 0;
    int          mismatches = 0;
    int          hold_requests = 0;

    // Register copies and per-text scan state of the predictor.
    logic [1:0]   reg_mode;
    logic [127:0] reg_needle;
    logic [4:0]   reg_len;
    logic [20:0]  reg_bound;
    logic [4:0]   needle_cps;
    logic [7:0]   win_byte [16];
    logic [15:0]  win_lead;
    logic [20:0]  cp_count;
    logic [1:0]   cont_due;
    logic [20:0]  last_stop;
    logic [20:0]  hit_count;
    logic [20:0]  best_start;
    logic         best_hit;
    logic         bad_text;

    // Sequence length announced by a lead byte, zero when the byte cannot lead.
    function automatic int lead_len(input logic [7:0] b);
        if ((b & 8'h80) == 8'h00) return 1;
        if ((b & 8'hE0) == 8'hC0) return 2;
        if ((b & 8'hF0) == 8'hE0) return 3;
        if ((b & 8'hF8) == 8'hF0) return 4;
        return 0;
    endfunction

    // Codepoints in the needle, zero when the needle is not valid UTF-8.
    function automatic logic [4:0] count_needle_cps(input logic [127:0] nb,
                                                    input logic [4:0] len);
        int pos;
        int need;
        int k;
        int cps;
        if (len == 0 || len > 16) return 5'd0;
        pos = 0;
        cps = 0;
        while (pos < len) begin
            need = lead_len(nb[pos*8 +: 8]);
            if (need == 0 || pos + need > len) return 5'd0;
            for (k = 1; k < need; k++) begin
                if (nb[(pos+k)*8+6 +: 2] != 2'b10) return 5'd0;
            end
            pos += need;
            cps++;
        end
        return cps[4:0];
    endfunction

    function automatic t_result make_result(input logic kind, input logic [20:0] first,
                                            input logic [20:0] stop, input logic [20:0] cnt,
                                            input logic [1:0] status);
        t_result r;
        r.kind   = kind;
        r.mstart = first;
        r.mend   = stop;
        r.mcount = cnt;
        r.status = status;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic clear_text_state();
        int k;
        for (k = 0; k < 16; k++) win_byte[k] = 8'h00;
        win_lead   = '0;
        cp_count   = '0;
        cont_due   = '0;
        last_stop  = '0;
        hit_count  = '0;
        best_start = '0;
        best_hit   = 1'b0;
        bad_text   = 1'b0;
    endtask

    task automatic write_search_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        case (idx)
            CFG_MODE:        reg_mode = value[1:0];
            CFG_NEEDLE_LOW:  reg_needle[63:0] = value;
            CFG_NEEDLE_HIGH: reg_needle[127:64] = value;
            CFG_NEEDLE_LEN:  reg_len = value[4:0];
            CFG_BOUND:       reg_bound = value[20:0];
            default: ;
        endcase
        needle_cps = count_needle_cps(reg_needle, reg_len);
    endtask

    task automatic reset_search_model();
        reg_mode   = MODE_ALL;
        reg_needle = '0;
        reg_len    = 5'd1;
        reg_bound  = '0;
        clear_text_state();
        needle_cps = count_needle_cps(reg_needle, reg_len);
    endtask

    // Decode one text byte, look for a match ending here and queue the results it causes.
    task automatic scan_text_byte(input logic [7:0] b, input logic fin);
        logic        lead;
        logic        complete;
        logic        hit;
        logic        out_of_range;
        logic [4:0]  ncp;
        logic [20:0] cp_stop;
        logic [20:0] cp_first;
        logic [20:0] total;
        logic [20:0] eff;
        t_result     res [2];
        int          n;
        int          k;
        int          len;
        lead     = 1'b0;
        complete = 1'b0;
        ncp      = needle_cps;
        n        = 0;

        // Continuation bytes finish a sequence; anything else cuts it and leads anew.
        if (cont_due != 0) begin
            if (b[7:6] == 2'b10) begin
                cont_due = cont_due - 1'b1;
                complete = (cont_due == 0);
            end else begin
                bad_text = 1'b1;
                cont_due = '0;
                lead     = 1'b1;
            end
        end else begin
            lead = 1'b1;
        end
        if (lead) begin
            if (cp_count >= TEXT_MAX_CODEPOINTS) bad_text = 1'b1;
            else cp_count = cp_count + 1'b1;
            case (lead_len(b))
                1: complete = 1'b1;
                2: cont_due = 2'd1;
                3: cont_due = 2'd2;
                4: cont_due = 2'd3;
                default: begin
                    bad_text = 1'b1;
                    complete = 1'b1;
                end
            endcase
        end

        for (k = 15; k > 0; k--) win_byte[k] = win_byte[k-1];
        win_byte[0] = b;
        win_lead    = {win_lead[14:0], lead};
        if (fin && cont_due != 0) bad_text = 1'b1;

        // The needle must sit in the window and start on a codepoint boundary.
        len = reg_len;
        hit = 1'b0;
        if (len >= 1 && len <= 16) begin
            hit = win_lead[len-1];
            for (k = 0; k < len; k++) begin
                if (win_byte[len-1-k] != reg_needle[k*8 +: 8]) hit = 1'b0;
            end
        end

        if (complete && !bad_text && ncp != 0 && cp_count >= ncp && hit) begin
            cp_stop  = cp_count;
            cp_first = cp_stop - ncp;
            case (reg_mode)
                MODE_ALL: begin
                    if (cp_first >= reg_bound && cp_first >= last_stop) begin
                        last_stop = cp_stop;
                        hit_count = hit_count + 1'b1;
                        res[n] = make_result(KIND_MATCH, cp_first, cp_stop, hit_count, ST_OK);
                        n++;
                    end
                end
                MODE_FIRST: begin
                    if (!best_hit && cp_first >= reg_bound) begin
                        best_hit   = 1'b1;
                        best_start = cp_first;
                        res[n] = make_result(KIND_MATCH, cp_first, cp_stop, '0, ST_OK);
                        n++;
                    end
                end
                MODE_LAST: begin
                    if (cp_stop <= reg_bound) begin
                        best_hit   = 1'b1;
                        best_start = cp_first;
                    end
                end
                default: ;
            endcase
        end

        // The last byte of a text always closes it with a summary.
        if (fin) begin
            total = cp_count;
            if (ncp == 0) begin
                res[n] = make_result(KIND_SUMMARY, '0, '0, '0, ST_INVALID);
            end else if (bad_text) begin
                res[n] = make_result(KIND_SUMMARY, '0, '0, '0, ST_MALFORMED);
            end else if (reg_mode == MODE_ALL) begin
                res[n] = make_result(KIND_SUMMARY, '0, '0, hit_count, ST_OK);
            end else if (reg_mode == MODE_FIRST || reg_mode == MODE_LAST) begin
                if (best_hit) begin
                    res[n] = make_result(KIND_SUMMARY, best_start, best_start + ncp, '0, ST_OK);
                end else begin
                    if (reg_mode == MODE_FIRST) begin
                        out_of_range = (total < ncp) || (reg_bound > total - ncp);
                    end else begin
                        eff = (reg_bound > total) ? total : reg_bound;
                        out_of_range = (reg_bound == 0) || (total < ncp) || (eff < ncp);
                    end
                    res[n] = make_result(KIND_SUMMARY, '0, '0, '0,
                                         out_of_range ? ST_INVALID : ST_NOT_FOUND);
                end
            end else begin
                res[n] = make_result(KIND_SUMMARY, '0, '0, '0, ST_INVALID);
            end
            n++;
            clear_text_state();
        end

        if (n > 0) res[n-1].last = 1'b1;
        for (k = 0; k < n; k++) awaited_results.push_back(res[k]);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Sender: one item in flight, fed in order from text_feed.
    int gap_left = 0;
    int burst_left = 0;
    int settle_count = 0;

    always @(posedge i_clk) begin : feed_drive
        t_feed_entry head;
        logic        next_byte_valid;
        logic        next_reg_valid;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_cfg_valid     <= 1'b0;
            reset_search_model();
        end else begin
            next_byte_valid = i_s_axis_tvalid;
            next_reg_valid  = i_cfg_valid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                scan_text_byte(i_s_axis_tdata, i_s_axis_tlast);
                next_byte_valid = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_search_reg(i_cfg_index, i_cfg_data);
                next_reg_valid = 1'b0;
            end

            if (!next_byte_valid && !next_reg_valid && text_feed.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    head = text_feed[0];
                    case (head.what)
                        FEED_BYTE: begin
                            head = text_feed.pop_front();
                            i_s_axis_tdata  <= head.data;
                            i_s_axis_tlast  <= head.final_byte;
                            next_byte_valid = 1'b1;
                            if (head.hold) hold_requests <= hold_requests + 1;
                            // Stretches without gaps alternate with choppy ones.
                            if (burst_left > 0) begin
                                burst_left--;
                                gap_left = 0;
                            end else if ($urandom_range(0, 49) == 0) begin
                                burst_left = $urandom_range(30, 100);
                                gap_left = 0;
                            end else begin
                                gap_left = $urandom_range(0, 1) ? 0 : pick_gap();
                            end
                        end
                        FEED_REG: begin
                            head = text_feed.pop_front();
                            i_cfg_index    <= head.index;
                            i_cfg_data     <= head.value;
                            next_reg_valid = 1'b1;
                        end
                        default: begin
                            // Sync point: wait for every result, then let the block settle.
                            if (awaited_results.size() == 0) begin
                                if (settle_count >= SETTLE_CYCLES) begin
                                    head = text_feed.pop_front();
                                    settle_count = 0;
                                end else begin
                                    settle_count++;
                                end
                            end else begin
                                settle_count = 0;
                            end
                        end
                    endcase
                end
            end
            i_s_axis_tvalid <= next_byte_valid;
            i_cfg_valid     <= next_reg_valid;
        end
    end

    // Receiver pacing, with one long hold-off when the driver asks for it.
    int stall_left = 0;
    int calm_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_requests) begin
                hold_seen  = hold_requests;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 99) < 2) begin
                    calm_left = $urandom_range(50, 300);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [20:0] want,
                               input logic [20:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result item is checked against the oldest awaited one.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind   = o_m_axis_tuser;
            got.mstart = o_m_axis_tdata[20:0];
            got.mend   = o_m_axis_tdata[41:21];
            got.mcount = o_m_axis_tdata[62:42];
            got.status = o_m_axis_tdata[64:63];
            got.last   = o_m_axis_tlast;
            if (awaited_results.size() == 0) begin
                $error("result item with none awaited: kind %0d start %0d end %0d status %0d",
                       got.kind, got.mstart, got.mend, got.status);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("match_start", want.mstart, got.mstart);
                check_field("match_end", want.mend, got.mend);
                check_field("match_total", want.mcount, got.mcount);
                check_field("status", want.status, got.status);
                check_field("last_result", want.last, got.last);
            end
        end
    end

    // Stimulus building.
    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        t_feed_entry e;
        e = '0;
        e.what  = FEED_REG;
        e.index = idx;
        e.value = value;
        text_feed.push_back(e);
    endtask

    task automatic add_sync();
        t_feed_entry e;
        e = '0;
        e.what = FEED_SYNC;
        text_feed.push_back(e);
    endtask

    // Half the time the unused upper bits of a narrow register carry junk.
    function automatic logic [63:0] with_junk(input logic [63:0] value, input int keep);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) return value;
        return (junk & ~((64'd1 << keep) - 64'd1)) | value;
    endfunction

    // Turn text_buf into byte items, the last one marked final.
    task automatic add_text(input logic hold_first);
        t_feed_entry e;
        int k;
        for (k = 0; k < text_buf.size(); k++) begin
            e = '0;
            e.what       = FEED_BYTE;
            e.data       = text_buf[k];
            e.final_byte = (k == text_buf.size() - 1);
            e.hold       = hold_first && (k == 0);
            text_feed.push_back(e);
        end
        bytes_queued += text_buf.size();
        text_buf.delete();
    endtask

    // Write needle_buf with the given length; bytes past it are random.
    task automatic add_needle(input logic [4:0] len);
        logic [127:0] nv;
        int k;
        nv = {$urandom, $urandom, $urandom, $urandom};
        for (k = 0; k < 16 && k < needle_buf.size(); k++) nv[k*8 +: 8] = needle_buf[k];
        add_reg(CFG_NEEDLE_LOW, nv[63:0]);
        add_reg(CFG_NEEDLE_HIGH, nv[127:64]);
        add_reg(CFG_NEEDLE_LEN, with_junk({59'd0, len}, 5));
    endtask

    // One codepoint, from a small alphabet so that matches are frequent, or random.
    task automatic emit_token(input bit to_needle);
        logic [31:0] w;
        logic [7:0]  lead_mask;
        logic [7:0]  lead_bits;
        int n;
        int k;
        case ($urandom_range(0, 7))
            0, 1: begin w = 32'h61; n = 1; end
            2: begin w = 32'h62; n = 1; end
            3: begin w = 32'hC3A9; n = 2; end
            4: begin w = 32'hE282AC; n = 3; end
            5: begin w = 32'hF09F9880; n = 4; end
            default: begin
                n = $urandom_range(1, 4);
                w = $urandom;
                case (n)
                    1: begin lead_mask = 8'h80; lead_bits = 8'h00; end
                    2: begin lead_mask = 8'hE0; lead_bits = 8'hC0; end
                    3: begin lead_mask = 8'hF0; lead_bits = 8'hE0; end
                    default: begin lead_mask = 8'hF8; lead_bits = 8'hF0; end
                endcase
                w[(n-1)*8 +: 8] = (w[(n-1)*8 +: 8] & ~lead_mask) | lead_bits;
                for (k = 0; k < n - 1; k++) w[k*8+6 +: 2] = 2'b10;
            end
        endcase
        for (k = 0; k < n; k++) begin
            if (to_needle) needle_buf.push_back(w[(n-1-k)*8 +: 8]);
            else text_buf.push_back(w[(n-1-k)*8 +: 8]);
        end
    endtask

    // A stray continuation, a byte that can never lead, or a sequence cut short.
    task automatic emit_break();
        case ($urandom_range(0, 2))
            0: text_buf.push_back({2'b10, 6'($urandom)});
            1: text_buf.push_back({5'b11111, 3'($urandom)});
            default: begin
                text_buf.push_back($urandom_range(0, 1) ? 8'hC3 : 8'hE2);
                if ($urandom_range(0, 1)) text_buf.push_back(8'h82);
                text_buf.push_back(8'h61);
            end
        endcase
    endtask

    task automatic add_random_phase();
        logic [1:0]  mode_sel;
        logic [20:0] bound;
        logic [4:0]  len;
        int ncp;
        int ntexts;
        int ntok;
        int break_at;
        int t;
        int k;
        logic broken;
        add_sync();
        mode_sel = ($urandom_range(0, 9) == 0) ? MODE_UNKNOWN : 2'($urandom_range(0, 2));
        add_reg(CFG_MODE, with_junk({62'd0, mode_sel}, 2));

        if ($urandom_range(0, 9) < 7) begin
            needle_buf.delete();
            ncp = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            for (k = 0; k < ncp; k++) emit_token(1'b1);
            len = (needle_buf.size() > 31) ? 5'd31 : 5'(needle_buf.size());
            case ($urandom_range(0, 19))
                0: len = 5'($urandom_range(0, 31));
                1: needle_buf[$urandom_range(0, needle_buf.size() - 1)] = 8'($urandom);
                default: ;
            endcase
            add_needle(len);
        end

        case ($urandom_range(0, 9))
            0: bound = 21'd0;
            1: bound = TEXT_MAX_CODEPOINTS;
            2: bound = 21'h1FFFFF;
            default: bound = (mode_sel == MODE_LAST) ? 21'($urandom_range(0, 20))
                                                     : 21'($urandom_range(0, 10));
        endcase
        add_reg(CFG_BOUND, with_junk({43'd0, bound}, 21));

        // Mostly well-formed texts dense with needle copies, a few broken ones.
        ntexts = $urandom_range(1, 3);
        for (t = 0; t < ntexts; t++) begin
            ntok     = $urandom_range(1, 12);
            broken   = ($urandom_range(0, 6) == 0);
            break_at = $urandom_range(0, ntok - 1);
            for (k = 0; k < ntok; k++) begin
                if (broken && k == break_at) emit_break();
                if (needle_buf.size() > 0 && $urandom_range(0, 2) == 0) begin
                    foreach (needle_buf[i]) text_buf.push_back(needle_buf[i]);
                end else begin
                    emit_token(1'b0);
                end
            end
            if ($urandom_range(0, 19) == 0) text_buf.push_back(8'hE2);
            add_text(1'b0);
        end
    endtask

    initial begin
        int k;
        logic hold_done;
        hold_done = 1'b0;

        // Directed texts. Reset needle is one zero byte in mode 0.
        text_buf = '{8'h00, 8'hFF};
        add_text(1'b0);

        // First match forward: two matches, the second one reported and summarized.
        add_sync();
        add_reg(CFG_MODE, {62'd0, MODE_FIRST});
        needle_buf = '{8'h61, 8'h62};
        add_needle(5'd2);
        add_reg(CFG_BOUND, 64'd1);
        text_buf = '{8'h61, 8'h62, 8'h61, 8'h62};
        add_text(1'b0);

        // Last match backward with a zero bound, then with a bound of TEXT_MAX_CODEPOINTS.
        add_sync();
        add_reg(CFG_MODE, {62'd0, MODE_LAST});
        needle_buf = '{8'hE2, 8'h82, 8'hAC};
        add_needle(5'd3);
        add_reg(CFG_BOUND, 64'd0);
        text_buf = '{8'hE2, 8'h82, 8'hAC};
        add_text(1'b0);
        add_sync();
        add_reg(CFG_BOUND, {43'd0, TEXT_MAX_CODEPOINTS});
        text_buf = '{8'hE2, 8'h82, 8'hAC};
        add_text(1'b0);

        // Unknown mode.
        add_sync();
        add_reg(CFG_MODE, {62'd0, MODE_UNKNOWN});
        text_buf = '{8'h78};
        add_text(1'b0);

        // Needle longer than the window is invalid.
        add_sync();
        add_reg(CFG_MODE, {62'd0, MODE_ALL});
        add_reg(CFG_NEEDLE_LEN, 64'd17);
        text_buf = '{8'h80};
        add_text(1'b0);

        // Stray continuation, a cut sequence, and a sequence cut by the final byte.
        add_sync();
        needle_buf = '{8'h61};
        add_needle(5'd1);
        add_reg(CFG_BOUND, 64'd0);
        text_buf = '{8'h80, 8'h61, 8'hC3, 8'h61, 8'h61};
        add_text(1'b0);
        text_buf = '{8'hE2, 8'h82};
        add_text(1'b0);

        // Four-byte needle: zero count, then a match on the final byte.
        add_sync();
        needle_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        add_needle(5'd4);
        text_buf = '{8'h61, 8'h62};
        add_text(1'b0);
        text_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        add_text(1'b0);

        // Random part, with one phase where every byte matches while the receiver holds off.
        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES) begin
            if (!hold_done && bytes_queued > RANDOM_BYTES / 2) begin
                hold_done = 1'b1;
                add_sync();
                add_reg(CFG_MODE, {62'd0, MODE_ALL});
                needle_buf = '{8'h61};
                add_needle(5'd1);
                add_reg(CFG_BOUND, 64'd0);
                for (k = 0; k < 40; k++) text_buf.push_back(8'h61);
                add_text(1'b1);
            end
            add_random_phase();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_feed.size() > 0 || i_s_axis_tvalid || i_cfg_valid
               || awaited_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("utf8_substring_search_unit test passed");
        end else begin
            $display("utf8_substring_search_unit test failed");
        end
        $finish;
    end

    // Give up long after the slowest correct run would have finished.
    initial begin
        #10_000_000;
        $display("utf8_substring_search_unit test failed");
        $finish;
    end

endmodule

>>> utf8_substring_search_unit.f
rtl/core/u8ss_pkg.sv
rtl/core/u8ss_needle.sv
rtl/core/u8ss_front.sv
rtl/core/u8ss_outq.sv
rtl/core/utf8_substring_search_unit.sv
test/testbench.sv
